>>> rtl/ccd_ik_pkg.sv
// Shared constants, types and tables for the CCD inverse-kinematics solver.
package ccd_ik_pkg;

  localparam int MAX_JOINTS   = 8;
  localparam int JW           = 3;              // joint index width
  localparam int NW           = 4;              // joint count width (holds MAX_JOINTS)
  localparam int FRAC_BITS    = 8;
  localparam int PW           = 16 + FRAC_BITS; // global position width
  localparam int CW           = 28;             // CORDIC datapath width
  localparam int AW           = 32;             // CORDIC angle width (full turn = 2^32)
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 5;
  localparam int PRW          = CW + 31;        // gain product width
  localparam longint INV_GAIN = 652032874;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_SOLVE  = 2'd1,
    CMD_REPORT = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  localparam logic CFG_JOINT_COUNT = 1'b0;
  localparam logic CFG_MAX_ITER    = 1'b1;

  typedef struct packed {
    logic start;
    logic vec;     // 1: vectoring (atan2), 0: rotation
  } cordic_req_t;

  typedef struct packed {
    logic [JW-1:0]      joint;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               no_joints;
    logic               last;
  } res_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_STEP,
    CS_G1,
    CS_G2,
    CS_G3
  } cordic_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EMPTY,
    S_FK_START,
    S_FK_BASE,
    S_FK_RD,
    S_FK_SEG,
    S_FK_ROT,
    S_AT_RD,
    S_AT_T,
    S_AT_TW,
    S_AT_EW,
    S_EM_RD,
    S_EM_OUT
  } core_state_t;

  // atan(2^-i) in 32-bit turns
  function automatic logic [AW-1:0] atan_turn(input logic [STEP_W-1:0] i);
    logic [AW-1:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/ccd_ik_cordic.sv
// Iterative CORDIC unit: rotation with gain correction, and atan2 by vectoring.
module ccd_ik_cordic
  import ccd_ik_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cordic_req_t          req,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  input  logic [AW-1:0]        ang_in,
  output logic                 done,
  output logic signed [CW-1:0] x_out,
  output logic signed [CW-1:0] y_out,
  output logic [AW-1:0]        ang_out
);

  localparam logic signed [PRW-1:0] GAIN_K = PRW'(INV_GAIN);
  localparam logic signed [PRW-1:0] RND    = PRW'(64'd1 << 29);

  cordic_state_t st_r, st_nxt;
  logic signed [CW-1:0]  x_r, x_nxt, y_r, y_nxt, xo_r, xo_nxt, yo_r, yo_nxt;
  logic signed [AW-1:0]  z_r, z_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic                  vec_r, vec_nxt, base_r, base_nxt, done_r, done_nxt;
  logic signed [PRW-1:0] prod_r, prod_nxt, prod_rnd;
  logic signed [CW-1:0]  sx, sy;
  logic signed [AW-1:0]  at;
  logic [1:0]            quad;

  always_comb begin
    st_nxt   = st_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    step_nxt = step_r;
    vec_nxt  = vec_r;
    base_nxt = base_r;
    prod_nxt = prod_r;
    xo_nxt   = xo_r;
    yo_nxt   = yo_r;
    done_nxt = 1'b0;
    sx       = x_r;
    sy       = y_r;
    sx       = y_r >>> step_r;
    sy       = x_r >>> step_r;
    at       = atan_turn(step_r);
    quad     = ang_in[AW-1:AW-2];
    prod_rnd = (prod_r + RND) >>> 30;
    case (st_r)
      CS_IDLE: begin
        if (req.start) begin
          vec_nxt  = req.vec;
          step_nxt = '0;
          base_nxt = 1'b0;
          x_nxt    = x_in;
          y_nxt    = y_in;
          if (req.vec) begin
            z_nxt = '0;
            if (x_in == '0 && y_in == '0) begin
              done_nxt = 1'b1;             // atan2(0,0) is zero
            end else begin
              if (x_in < 0) begin
                x_nxt    = -x_in;
                y_nxt    = -y_in;
                base_nxt = 1'b1;
              end
              st_nxt = CS_STEP;
            end
          end else begin
            z_nxt = ang_in;
            if (quad == 2'b01 || quad == 2'b10) begin
              x_nxt = -x_in;
              y_nxt = -y_in;
              z_nxt = ang_in + {1'b1, {(AW-1){1'b0}}};
            end
            st_nxt = CS_STEP;
          end
        end
      end
      CS_STEP: begin
        if (vec_r) begin
          if (y_r > 0) begin
            x_nxt = x_r + sx; y_nxt = y_r - sy; z_nxt = z_r + at;
          end else begin
            x_nxt = x_r - sx; y_nxt = y_r + sy; z_nxt = z_r - at;
          end
        end else begin
          if (!z_r[AW-1]) begin
            x_nxt = x_r - sx; y_nxt = y_r + sy; z_nxt = z_r - at;
          end else begin
            x_nxt = x_r + sx; y_nxt = y_r - sy; z_nxt = z_r + at;
          end
        end
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
          if (vec_r) begin
            done_nxt = 1'b1;
            st_nxt   = CS_IDLE;
          end else begin
            st_nxt = CS_G1;
          end
        end
      end
      CS_G1: begin
        prod_nxt = PRW'(x_r) * GAIN_K;
        st_nxt   = CS_G2;
      end
      CS_G2: begin
        xo_nxt   = prod_rnd[CW-1:0];
        prod_nxt = PRW'(y_r) * GAIN_K;
        st_nxt   = CS_G3;
      end
      CS_G3: begin
        yo_nxt   = prod_rnd[CW-1:0];
        done_nxt = 1'b1;
        st_nxt   = CS_IDLE;
      end
      default: st_nxt = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= CS_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    step_r <= step_nxt;
    vec_r  <= vec_nxt;
    base_r <= base_nxt;
    prod_r <= prod_nxt;
    xo_r   <= xo_nxt;
    yo_r   <= yo_nxt;
  end

  assign done    = done_r;
  assign x_out   = xo_r;
  assign y_out   = yo_r;
  assign ang_out = z_r + {base_r, {(AW-1){1'b0}}};

endmodule

>>> rtl/ccd_ik_core.sv
// Solver sequencer: joint memories, forward kinematics, CCD update and result reads.
module ccd_ik_core
  import ccd_ik_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic [JW-1:0]      in_joint_index,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_wdata,
  output logic               res_valid,
  input  logic               res_ready,
  output res_t               res
);

  localparam logic signed [PW:0] POS_MAX = (PW+1)'((64'd1 << (PW-1)) - 1);
  localparam logic signed [PW:0] POS_MIN = -(PW+1)'(64'd1 << (PW-1));

  // memories, read data registered
  logic [31:0]   rest_mem [MAX_JOINTS];
  logic [15:0]   ang_mem  [MAX_JOINTS];
  logic [2*PW-1:0] gl_mem [MAX_JOINTS];
  logic [MAX_JOINTS-1:0] ang_vld_r;
  logic [31:0]   rest_q;
  logic [15:0]   ang_q;
  logic          ang_vq;
  logic [2*PW-1:0] gl_q;

  logic [JW-1:0] rest_ra, ang_ra, gl_ra, rest_wa, ang_wa, gl_wa;
  logic          rest_we, ang_we, gl_we;
  logic [31:0]   rest_wd;
  logic [15:0]   ang_wd;
  logic [2*PW-1:0] gl_wd;

  core_state_t st_r, st_nxt;
  logic [NW-1:0] jc_r, n_r, n_nxt, k_r, k_nxt, n_cfg;
  logic [7:0]    mi_r, it_r, it_nxt;
  logic [JW-1:0] j_r, j_nxt;
  logic          solve_r, solve_nxt;
  logic signed [PW-1:0] tx_r, tx_nxt, ty_r, ty_nxt;
  logic signed [PW-1:0] pgx_r, pgx_nxt, pgy_r, pgy_nxt, gjx_r, gjx_nxt, gjy_r, gjy_nxt;
  logic signed [15:0]   prx_r, prx_nxt, pry_r, pry_nxt;
  logic [15:0]   acc_r, acc_nxt, angj_r, angj_nxt, ang_rd, inc;
  logic [AW-1:0] at_r, at_nxt, delta;

  cordic_req_t          creq;
  logic signed [CW-1:0] cx, cy, crx, cry;
  logic [AW-1:0]        cang, cang_out;
  logic                 cdone;

  logic signed [PW-1:0] rqx, rqy, gqx, gqy, sat_x, sat_y;
  logic signed [16:0]   rdx, rdy;
  logic signed [CW:0]   sum_x, sum_y;
  logic signed [PW:0]   pix_x, pix_y;

  ccd_ik_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (creq),
    .x_in   (cx),
    .y_in   (cy),
    .ang_in (cang),
    .done   (cdone),
    .x_out  (crx),
    .y_out  (cry),
    .ang_out(cang_out)
  );

  always_comb begin
    n_cfg = (jc_r > NW'(MAX_JOINTS)) ? NW'(MAX_JOINTS) : jc_r;
    rqx   = PW'($signed(rest_q[31:16])) <<< FRAC_BITS;
    rqy   = PW'($signed(rest_q[15:0])) <<< FRAC_BITS;
    gqx   = $signed(gl_q[2*PW-1:PW]);
    gqy   = $signed(gl_q[PW-1:0]);
    rdx   = 17'($signed(rest_q[31:16])) - 17'(prx_r);
    rdy   = 17'($signed(rest_q[15:0])) - 17'(pry_r);
    ang_rd = ang_vq ? ang_q : 16'd0;
    sum_x = (CW+1)'(pgx_r) + (CW+1)'(crx);
    sum_y = (CW+1)'(pgy_r) + (CW+1)'(cry);
    sat_x = (sum_x > POS_MAX) ? PW'(POS_MAX) : (sum_x < POS_MIN) ? PW'(POS_MIN) : PW'(sum_x);
    sat_y = (sum_y > POS_MAX) ? PW'(POS_MAX) : (sum_y < POS_MIN) ? PW'(POS_MIN) : PW'(sum_y);
    delta = at_r - cang_out;
    inc   = 16'((delta + 32'h8000) >> 16);
    pix_x = ((PW+1)'(gqx) + (PW+1)'(1 << (FRAC_BITS-1))) >>> FRAC_BITS;
    pix_y = ((PW+1)'(gqy) + (PW+1)'(1 << (FRAC_BITS-1))) >>> FRAC_BITS;
  end

  always_comb begin
    st_nxt    = st_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    it_nxt    = it_r;
    solve_nxt = solve_r;
    tx_nxt    = tx_r;
    ty_nxt    = ty_r;
    pgx_nxt   = pgx_r;
    pgy_nxt   = pgy_r;
    gjx_nxt   = gjx_r;
    gjy_nxt   = gjy_r;
    prx_nxt   = prx_r;
    pry_nxt   = pry_r;
    acc_nxt   = acc_r;
    angj_nxt  = angj_r;
    at_nxt    = at_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    creq      = '0;
    cx        = '0;
    cy        = '0;
    cang      = '0;
    rest_ra   = k_r[JW-1:0];
    ang_ra    = JW'(k_r - 1'b1);
    gl_ra     = k_r[JW-1:0];
    rest_we   = 1'b0;
    rest_wa   = in_joint_index;
    rest_wd   = {in_pos_x, in_pos_y};
    ang_we    = 1'b0;
    ang_wa    = in_joint_index;
    ang_wd    = '0;
    gl_we     = 1'b0;
    gl_wa     = k_r[JW-1:0];
    gl_wd     = {sat_x, sat_y};
    case (st_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          n_nxt  = n_cfg;
          tx_nxt = PW'(in_pos_x) <<< FRAC_BITS;
          ty_nxt = PW'(in_pos_y) <<< FRAC_BITS;
          case (cmd_t'(in_command))
            CMD_LOAD: begin
              rest_we = 1'b1;
              ang_we  = 1'b1;
            end
            CMD_SOLVE, CMD_REPORT: begin
              if (n_cfg == '0) begin
                st_nxt = S_EMPTY;
              end else begin
                solve_nxt = (cmd_t'(in_command) == CMD_SOLVE) && (mi_r != '0);
                j_nxt     = JW'(n_cfg - 1'b1);
                it_nxt    = '0;
                st_nxt    = S_FK_START;
              end
            end
            default: ;
          endcase
        end
      end
      S_EMPTY: begin
        res_valid     = 1'b1;
        res.no_joints = 1'b1;
        res.last      = 1'b1;
        if (res_ready) st_nxt = S_IDLE;
      end
      S_FK_START: begin
        rest_ra = '0;
        st_nxt  = S_FK_BASE;
      end
      S_FK_BASE: begin
        gl_we   = 1'b1;
        gl_wa   = '0;
        gl_wd   = {rqx, rqy};
        pgx_nxt = rqx;
        pgy_nxt = rqy;
        prx_nxt = $signed(rest_q[31:16]);
        pry_nxt = $signed(rest_q[15:0]);
        acc_nxt = '0;
        k_nxt   = NW'(1);
        if (n_r == NW'(1)) begin
          k_nxt  = '0;
          st_nxt = solve_r ? S_AT_RD : S_EM_RD;
        end else begin
          st_nxt = S_FK_RD;
        end
      end
      S_FK_RD: begin
        st_nxt = S_FK_SEG;
      end
      S_FK_SEG: begin
        acc_nxt    = acc_r + ang_rd;
        prx_nxt    = $signed(rest_q[31:16]);
        pry_nxt    = $signed(rest_q[15:0]);
        creq.start = 1'b1;
        creq.vec   = 1'b0;
        cx         = CW'(rdx) <<< FRAC_BITS;
        cy         = CW'(rdy) <<< FRAC_BITS;
        cang       = {acc_nxt, 16'd0};
        st_nxt     = S_FK_ROT;
      end
      S_FK_ROT: begin
        if (cdone) begin
          gl_we   = 1'b1;
          pgx_nxt = sat_x;
          pgy_nxt = sat_y;
          if (k_r == n_r - 1'b1) begin
            k_nxt  = '0;
            st_nxt = solve_r ? S_AT_RD : S_EM_RD;
          end else begin
            k_nxt  = k_r + 1'b1;
            st_nxt = S_FK_RD;
          end
        end
      end
      S_AT_RD: begin
        gl_ra  = j_r;
        ang_ra = j_r;
        st_nxt = S_AT_T;
      end
      S_AT_T: begin
        gjx_nxt    = gqx;
        gjy_nxt    = gqy;
        angj_nxt   = ang_rd;
        creq.start = 1'b1;
        creq.vec   = 1'b1;
        cx         = CW'(tx_r) - CW'(gqx);
        cy         = CW'(ty_r) - CW'(gqy);
        st_nxt     = S_AT_TW;
      end
      S_AT_TW: begin
        if (cdone) begin
          at_nxt     = cang_out;
          creq.start = 1'b1;
          creq.vec   = 1'b1;
          cx         = CW'(pgx_r) - CW'(gjx_r);
          cy         = CW'(pgy_r) - CW'(gjy_r);
          st_nxt     = S_AT_EW;
        end
      end
      S_AT_EW: begin
        if (cdone) begin
          ang_we = 1'b1;
          ang_wa = j_r;
          ang_wd = angj_r + inc;
          st_nxt = S_FK_START;
          if (j_r == '0) begin
            it_nxt = it_r + 1'b1;
            j_nxt  = JW'(n_r - 1'b1);
            if (it_nxt == mi_r) solve_nxt = 1'b0;
          end else begin
            j_nxt = j_r - 1'b1;
          end
        end
      end
      S_EM_RD: begin
        st_nxt = S_EM_OUT;
      end
      S_EM_OUT: begin
        res_valid = 1'b1;
        res.joint = k_r[JW-1:0];
        res.x     = (pix_x > 17'sd32767) ? 16'sh7fff :
                    (pix_x < -17'sd32768) ? 16'sh8000 : 16'(pix_x);
        res.y     = (pix_y > 17'sd32767) ? 16'sh7fff :
                    (pix_y < -17'sd32768) ? 16'sh8000 : 16'(pix_y);
        res.last  = (k_r == n_r - 1'b1);
        if (res_ready) begin
          if (res.last) begin
            st_nxt = S_IDLE;
          end else begin
            k_nxt  = k_r + 1'b1;
            st_nxt = S_EM_RD;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // memories: one write and one registered read each; the sequence never
  // uses read data of an entry from the cycle it is written
  always_ff @(posedge clk) begin
    if (rest_we) rest_mem[rest_wa] <= rest_wd;
    if (ang_we)  ang_mem[ang_wa]   <= ang_wd;
    if (gl_we)   gl_mem[gl_wa]     <= gl_wd;
    rest_q <= rest_mem[rest_ra];
    ang_q  <= ang_mem[ang_ra];
    ang_vq <= ang_vld_r[ang_ra];
    gl_q   <= gl_mem[gl_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      jc_r      <= '0;
      mi_r      <= 8'd10;
      ang_vld_r <= '0;
      solve_r   <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      solve_r <= solve_nxt;
      if (ang_we) ang_vld_r[ang_wa] <= 1'b1;
      if (cfg_we) begin
        if (cfg_index == CFG_JOINT_COUNT) jc_r <= cfg_wdata[NW-1:0];
        if (cfg_index == CFG_MAX_ITER)    mi_r <= cfg_wdata;
      end
    end
    n_r    <= n_nxt;
    k_r    <= k_nxt;
    j_r    <= j_nxt;
    it_r   <= it_nxt;
    tx_r   <= tx_nxt;
    ty_r   <= ty_nxt;
    pgx_r  <= pgx_nxt;
    pgy_r  <= pgy_nxt;
    gjx_r  <= gjx_nxt;
    gjy_r  <= gjy_nxt;
    prx_r  <= prx_nxt;
    pry_r  <= pry_nxt;
    acc_r  <= acc_nxt;
    angj_r <= angj_nxt;
    at_r   <= at_nxt;
  end

endmodule

>>> rtl/ccd_inverse_kinematics_2d_unit.sv
// Top level of the planar CCD inverse-kinematics solver with its output register.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------------
//   in       | in_valid / in_ready  | in_command, in_joint_index, in_pos_x, in_pos_y
//   out      | out_valid / out_ready| out_joint, out_x, out_y, out_no_joints, out_last
//   cfg      | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// Load: no result. Report: one beat per joint for n joints; n = 0 gives a no_joints beat.
// Solve: max_iterations sweeps of joint updates plus a final report; the
// iterative CORDIC unit (16 steps, gain states G1 to G3 and a registered done per
// rotation; steps and done per atan2) sets the pace, one item in flight at a time.
// Reset (rst_n low, synchronous) clears the sequencer, joint count and joint angles
// and sets max_iterations to 10. A stalled out channel holds the result beat in the
// output register and the sequencer waits behind it; a new input beat is taken once
// the last result is handed to that register.
module ccd_inverse_kinematics_2d_unit
  import ccd_ik_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic [2:0]         in_joint_index,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_joint,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic               out_no_joints,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_wdata
);

  logic res_valid, res_ready;
  res_t res;
  logic out_valid_r, out_valid_nxt;
  res_t out_r;

  ccd_ik_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_joint_index(in_joint_index),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  // output register: refills in the cycle its beat is taken
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (res_valid && res_ready) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_valid && res_ready) out_r <= res;
  end

  assign out_valid     = out_valid_r;
  assign out_joint     = out_r.joint;
  assign out_x         = out_r.x;
  assign out_y         = out_r.y;
  assign out_no_joints = out_r.no_joints;
  assign out_last      = out_r.last;

`ifndef SYNTHESIS
  // empty-chain error is always a single, final beat
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_joints |-> out_last)
    else $error("empty-chain result without last");

  // empty-chain error carries zero payload
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_joints |-> out_x == '0 && out_y == '0 && out_joint == '0)
    else $error("empty-chain result with payload");

  // sequencer only produces results while it is busy with an item
  a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !in_ready)
    else $error("result produced while idle");
`endif

endmodule

>>> sim/ccd_ik_checker.sv
// Predictor and result checker for the CCD inverse-kinematics solver.
`timescale 1ns / 1ps

module ccd_ik_checker
  import ccd_ik_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic [2:0]         in_joint_index,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         out_joint,
  input  logic signed [15:0] out_x,
  input  logic signed [15:0] out_y,
  input  logic               out_no_joints,
  input  logic               out_last,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_wdata,
  output int                 fail_count,
  output int                 pending
);

  localparam longint ATAN_T [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861};
  localparam longint POS_LO = -(longint'(32768) << FRAC_BITS);
  localparam longint POS_HI = (longint'(32768) << FRAC_BITS) - 1;

  logic [3:0]  n_joints;
  logic [7:0]  sweeps;
  longint      rest_px [MAX_JOINTS];
  longint      rest_py [MAX_JOINTS];
  logic [15:0] angle [MAX_JOINTS];
  longint      gx [MAX_JOINTS];
  longint      gy [MAX_JOINTS];
  res_t        expected_positions [$];

  assign pending = expected_positions.size();

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // vectors rotated by a 32-bit turn, gain removed with rounding
  function automatic void rotate_vec(inout longint x, inout longint y, input logic [31:0] ang);
    longint z, dx, dy;
    if (ang[31:30] == 2'b01 || ang[31:30] == 2'b10) begin
      x = -x;
      y = -y;
      ang = ang + 32'h8000_0000;
    end
    z = longint'($signed(ang));
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_T[i];
      end else begin
        x += dx; y -= dy; z += ATAN_T[i];
      end
    end
    x = (x * INV_GAIN + (longint'(1) << 29)) >>> 30;
    y = (y * INV_GAIN + (longint'(1) << 29)) >>> 30;
  endfunction

  function automatic logic [31:0] heading(input longint y, input longint x);
    logic [31:0] base;
    longint z, sx, sy;
    base = '0;
    z = 0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      base = 32'h8000_0000;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      sx = y >>> i;
      sy = x >>> i;
      if (y > 0) begin
        x += sx; y -= sy; z += ATAN_T[i];
      end else begin
        x -= sx; y += sy; z -= ATAN_T[i];
      end
    end
    return base + z[31:0];
  endfunction

  function automatic longint clamp_pos(input longint v);
    return v < POS_LO ? POS_LO : (v > POS_HI ? POS_HI : v);
  endfunction

  function automatic logic [15:0] to_pixel(input longint v);
    longint r;
    r = (v + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic void chain_positions(input int n);
    logic [15:0] acc;
    longint dx, dy;
    acc = '0;
    if (n == 0) return;
    gx[0] = rest_px[0] <<< FRAC_BITS;
    gy[0] = rest_py[0] <<< FRAC_BITS;
    for (int i = 1; i < n; i++) begin
      dx = (rest_px[i] - rest_px[i-1]) <<< FRAC_BITS;
      dy = (rest_py[i] - rest_py[i-1]) <<< FRAC_BITS;
      acc = acc + angle[i-1];
      rotate_vec(dx, dy, {acc, 16'h0});
      gx[i] = clamp_pos(gx[i-1] + dx);
      gy[i] = clamp_pos(gy[i-1] + dy);
    end
  endfunction

  function automatic void solve_chain(input int n, input longint tx, input longint ty);
    logic [31:0] d, t;
    for (int it = 0; it < sweeps; it++)
      for (int i = n - 1; i >= 0; i--) begin
        chain_positions(n);
        d = heading(ty - gy[i], tx - gx[i]) -
            heading(gy[n-1] - gy[i], gx[n-1] - gx[i]);
        t = d + 32'h8000;
        angle[i] = angle[i] + t[31:16];
      end
  endfunction

  function automatic void predict_beat(input cmd_t cmd, input logic [2:0] idx,
                                       input logic signed [15:0] px,
                                       input logic signed [15:0] py);
    int n;
    res_t r;
    n = (n_joints > MAX_JOINTS) ? MAX_JOINTS : int'(n_joints);
    case (cmd)
      CMD_LOAD: begin
        rest_px[idx] = px;
        rest_py[idx] = py;
        angle[idx]   = '0;
      end
      CMD_SOLVE, CMD_REPORT: begin
        if (n == 0) begin
          r = '{joint: '0, x: '0, y: '0, no_joints: 1'b1, last: 1'b1};
          expected_positions.push_back(r);
        end else begin
          if (cmd == CMD_SOLVE)
            solve_chain(n, longint'(px) <<< FRAC_BITS, longint'(py) <<< FRAC_BITS);
          chain_positions(n);
          for (int i = 0; i < n; i++) begin
            r.joint = i[2:0];
            r.x = to_pixel(gx[i]);
            r.y = to_pixel(gy[i]);
            r.no_joints = 1'b0;
            r.last = (i == n - 1);
            expected_positions.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  initial fail_count = 0;

  always @(posedge clk) begin
    res_t w;
    if (!rst_n) begin
      n_joints = '0;
      sweeps   = 8'd10;
      foreach (angle[i]) begin
        angle[i] = '0;
        rest_px[i] = 0;
        rest_py[i] = 0;
      end
      expected_positions.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_JOINT_COUNT) n_joints = cfg_wdata[3:0];
        else sweeps = cfg_wdata;
      end
      if (out_valid && out_ready) begin
        if (expected_positions.size() == 0) begin
          $display("[%0t] mismatch: result beat with nothing expected", $realtime);
          fail_count++;
        end else begin
          w = expected_positions.pop_front();
          if (out_joint !== w.joint) report_mismatch("out_joint", out_joint, w.joint);
          if (out_x !== w.x) report_mismatch("out_x", out_x, w.x);
          if (out_y !== w.y) report_mismatch("out_y", out_y, w.y);
          if (out_no_joints !== w.no_joints)
            report_mismatch("out_no_joints", out_no_joints, w.no_joints);
          if (out_last !== w.last) report_mismatch("out_last", out_last, w.last);
        end
      end
      if (in_valid && in_ready)
        predict_beat(cmd_t'(in_command), in_joint_index, in_pos_x, in_pos_y);
    end
  end

endmodule

>>> sim/testbench.sv
// Top of the CCD inverse-kinematics testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import ccd_ik_pkg::*;

  // Worst case here is a handful of 8-joint solves at a few sweeps plus three
  // 255-sweep solves on short chains; this leaves a wide margin.
  localparam int LIMIT = 3_000_000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_command = CMD_NONE;
  logic [2:0]         in_joint_index = '0;
  logic signed [15:0] in_pos_x = '0;
  logic signed [15:0] in_pos_y = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_joint;
  logic signed [15:0] out_x, out_y;
  logic               out_no_joints, out_last;
  logic               cfg_we = 1'b0;
  logic               cfg_index = CFG_JOINT_COUNT;
  logic [7:0]         cfg_wdata = '0;
  logic               hold_req = 1'b0;   // asks the receiver for one long hold-off
  int                 fail_count, pending;
  int                 cycles = 0;

  always #4 clk = ~clk;

  ccd_inverse_kinematics_2d_unit uut (.*);

  ccd_ik_checker chk (.*);

  // mostly back-to-back or short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold so the block backs up
  initial begin
    int g;
    bit held = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req && !held) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
      end
      g = gap_len();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // one input beat; valid stays up across back-to-back beats
  task automatic send_beat(input cmd_t cmd, input logic [2:0] idx,
                           input logic signed [15:0] px, input logic signed [15:0] py);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_joint_index <= idx;
    in_pos_x       <= px;
    in_pos_y       <= py;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // wait for the block to drain, then let a load finish before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_coord();
    // mostly a sensible working area, sometimes anywhere in range
    if ($urandom_range(0, 4) == 0) return 16'($urandom());
    return $signed(16'($urandom_range(0, 800))) - 16'sd400;
  endfunction

  initial begin
    cmd_t c;
    int r;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    // empty chain: error beat for report and solve; unused command dropped
    send_beat(CMD_REPORT, 3'd0, 16'sd0, 16'sd0);
    send_beat(CMD_SOLVE, 3'd7, 16'sd100, -16'sd100);
    send_beat(CMD_NONE, 3'd5, 16'sd1, 16'sd1);
    // chain with extreme and ordinary rest points
    send_beat(CMD_LOAD, 3'd0, 16'sd0, 16'sd0);
    send_beat(CMD_LOAD, 3'd1, 16'sd40, 16'sd0);
    send_beat(CMD_LOAD, 3'd2, 16'sd80, 16'sd10);
    send_beat(CMD_LOAD, 3'd3, 16'sd100, -16'sd30);
    send_beat(CMD_LOAD, 3'd4, 16'sd32767, -16'sd32768);   // saturating segment
    send_beat(CMD_LOAD, 3'd5, -16'sd32768, 16'sd32767);
    send_beat(CMD_LOAD, 3'd6, -16'sd1, -16'sd1);
    send_beat(CMD_LOAD, 3'd7, 16'sd5, 16'sd5);
    drain();
    write_reg(CFG_JOINT_COUNT, 8'd8);
    write_reg(CFG_MAX_ITER, 8'd1);
    send_beat(CMD_REPORT, 3'd0, 16'sd0, 16'sd0);
    send_beat(CMD_SOLVE, 3'd0, -16'sd32768, 16'sd32767);
    drain();
    write_reg(CFG_JOINT_COUNT, 8'd15);      // above the maximum acts as full chain
    write_reg(CFG_MAX_ITER, 8'd0);          // no sweeps: positions only
    send_beat(CMD_SOLVE, 3'd0, 16'sd32767, -16'sd32768);
    drain();
    write_reg(CFG_JOINT_COUNT, 8'd1);
    write_reg(CFG_MAX_ITER, 8'd255);
    send_beat(CMD_SOLVE, 3'd0, 16'sd50, 16'sd50);
    drain();
    write_reg(CFG_JOINT_COUNT, 8'd2);
    send_beat(CMD_LOAD, 3'd1, 16'sd60, 16'sd0);
    send_beat(CMD_SOLVE, 3'd0, 16'sd20, 16'sd40);
    send_beat(CMD_SOLVE, 3'd0, 16'sd0, 16'sd0);   // target on the base
    drain();

    // --- random phases ---
    for (int ph = 0; ph < 8; ph++) begin
      r = $urandom_range(0, 9);
      if (r == 0) write_reg(CFG_JOINT_COUNT, 8'd0);
      else if (r == 1) write_reg(CFG_JOINT_COUNT, 8'($urandom_range(9, 15)));
      else write_reg(CFG_JOINT_COUNT, 8'($urandom_range(1, 8)));
      write_reg(CFG_MAX_ITER, 8'($urandom_range(1, 3)));
      if (ph == 3) hold_req <= 1'b1;
      for (int k = 0; k < 12; k++) begin
        r = $urandom_range(0, 99);
        c = r < 30 ? CMD_LOAD : r < 70 ? CMD_SOLVE : r < 95 ? CMD_REPORT : CMD_NONE;
        send_beat(c, 3'($urandom()), rand_coord(), rand_coord());
        if (ph == 5 && k == 5) begin
          // sender waits for everything outstanding before carrying on
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
      drain();
    end

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/ccd_ik_pkg.sv
rtl/ccd_ik_cordic.sv
rtl/ccd_ik_core.sv
rtl/ccd_inverse_kinematics_2d_unit.sv
sim/ccd_ik_checker.sv
sim/testbench.sv
